// ===== rtl/rat_pkg.sv =====
package rat_pkg;

   localparam int PRED_COUNT = 32;
   localparam int RULE_COUNT = 64;
   localparam int PRED_W     = 5;
   localparam int RULE_W     = 6;
   localparam int COUNT_W    = 32;
   localparam int AVAIL_W    = 8;
   localparam int TOTAL_W    = 8;

   typedef enum logic [2:0] {
      FN_LOAD_PRED     = 3'd0,
      FN_LOAD_RULE     = 3'd1,
      FN_REGISTER      = 3'd2,
      FN_DEREGISTER    = 3'd3,
      FN_SET_COUNT     = 3'd4,
      FN_CLEAR_TOUCHED = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_FINISH
   } state_type;

   // rule table write (load rule)
   typedef struct packed {
      logic                  we;
      logic [RULE_W-1:0]     idx;
      logic [TOTAL_W-1:0]    total;
      logic                  persistent;
   } rule_wr_type;

   // availability walk request
   typedef struct packed {
      logic                  start;
      logic                  up;
      logic [RULE_COUNT-1:0] mask;
   } walk_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [RULE_COUNT-1:0] active;
      logic [RULE_COUNT-1:0] dropped;
   } walk_sts_type;

endpackage

// ===== rtl/rat_walker.sv =====
module rat_walker
   import rat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rule_wr_type  rule_wr,
   input  walk_cmd_type walk_cmd,
   output walk_sts_type walk_sts
);

   localparam logic [RULE_W-1:0] LAST_RULE = RULE_W'(RULE_COUNT - 1);

   logic [AVAIL_W-1:0] avail_mem [RULE_COUNT];
   logic [TOTAL_W:0]   rcfg_mem  [RULE_COUNT];   // {persistent, total}

   logic [RULE_COUNT-1:0] avail_vld_ff, avail_vld_in;
   logic [RULE_COUNT-1:0] rcfg_vld_ff, rcfg_vld_in;
   logic [RULE_COUNT-1:0] active_ff, active_in;
   logic [RULE_COUNT-1:0] dropped_ff, dropped_in;
   logic [RULE_COUNT-1:0] mask_ff, mask_in;
   logic                  run_ff, run_in;
   logic                  up_ff, up_in;
   logic [RULE_W-1:0]     idx_ff, idx_in;
   logic                  s1_vld_ff;
   logic [RULE_W-1:0]     s1_idx_ff;
   logic                  s1_sel_ff;
   logic [AVAIL_W-1:0]    avail_rd_ff;
   logic [TOTAL_W:0]      rcfg_rd_ff;

   logic [AVAIL_W-1:0]    avail_cur;
   logic [AVAIL_W-1:0]    avail_new;
   logic [TOTAL_W:0]      rcfg_cur;
   logic                  upd_we;
   logic                  hit;
   logic [RULE_COUNT-1:0] s1_bit;

   // memories: one read address (walk index), registered data
   always_ff @(posedge clock) begin
      if (rule_wr.we) begin
         rcfg_mem[rule_wr.idx] <= {rule_wr.persistent, rule_wr.total};
      end
      if (upd_we) begin
         avail_mem[s1_idx_ff] <= avail_new;
      end
      avail_rd_ff <= avail_mem[idx_ff];
      rcfg_rd_ff  <= rcfg_mem[idx_ff];
      s1_idx_ff   <= idx_ff;
      s1_sel_ff   <= mask_ff[idx_ff];
   end

   // update stage: one 8-bit inc/dec and compare per cycle
   always_comb begin
      avail_cur = avail_vld_ff[s1_idx_ff] ? avail_rd_ff : '0;
      rcfg_cur  = rcfg_vld_ff[s1_idx_ff] ? rcfg_rd_ff : '0;
      upd_we    = s1_vld_ff && s1_sel_ff && !rcfg_cur[TOTAL_W];
      avail_new = up_ff ? AVAIL_W'(avail_cur + 1'b1) : AVAIL_W'(avail_cur - 1'b1);
      hit       = up_ff ? (avail_new == rcfg_cur[TOTAL_W-1:0])
                        : (avail_cur == rcfg_cur[TOTAL_W-1:0]);
      s1_bit    = RULE_COUNT'(1) << s1_idx_ff;

      avail_vld_in = avail_vld_ff | (upd_we ? s1_bit : '0);
      rcfg_vld_in  = rcfg_vld_ff | (rule_wr.we ? (RULE_COUNT'(1) << rule_wr.idx) : '0);

      active_in  = active_ff;
      dropped_in = dropped_ff;
      if (upd_we && hit) begin
         if (up_ff) begin
            active_in  = active_ff | s1_bit;
            dropped_in = dropped_ff & ~s1_bit;
         end else begin
            active_in  = active_ff & ~s1_bit;
            dropped_in = dropped_ff | s1_bit;
         end
      end

      run_in  = run_ff;
      idx_in  = idx_ff;
      up_in   = up_ff;
      mask_in = mask_ff;
      if (walk_cmd.start) begin
         run_in  = 1'b1;
         idx_in  = '0;
         up_in   = walk_cmd.up;
         mask_in = walk_cmd.mask;
      end else if (run_ff) begin
         idx_in = RULE_W'(idx_ff + 1'b1);
         if (idx_ff == LAST_RULE) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_vld_ff <= '0;
         rcfg_vld_ff  <= '0;
         active_ff    <= '0;
         dropped_ff   <= '0;
         run_ff       <= 1'b0;
         s1_vld_ff    <= 1'b0;
         idx_ff       <= '0;
      end else begin
         avail_vld_ff <= avail_vld_in;
         rcfg_vld_ff  <= rcfg_vld_in;
         active_ff    <= active_in;
         dropped_ff   <= dropped_in;
         run_ff       <= run_in;
         s1_vld_ff    <= run_ff;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff   <= up_in;
      mask_ff <= mask_in;
   end

   assign walk_sts.done    = s1_vld_ff && (s1_idx_ff == LAST_RULE);
   assign walk_sts.active  = active_ff;
   assign walk_sts.dropped = dropped_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      walk_cmd.start |-> !run_ff && !s1_vld_ff)
      else $error("walk started while busy");

   a_wr_idle : assert property (@(posedge clock) disable iff (reset)
      rule_wr.we |-> !run_ff && !s1_vld_ff)
      else $error("rule table written during walk");

   a_maps_disjoint : assert property (@(posedge clock) disable iff (reset)
      (active_ff & dropped_ff) == '0)
      else $error("rule both active and dropped");

   a_done_ends : assert property (@(posedge clock) disable iff (reset)
      walk_sts.done |=> !s1_vld_ff && !run_ff)
      else $error("walk continues after done");

endmodule

// ===== rtl/rule_activation_tracker.sv =====
// Rule activation tracker.
//
// Request channel (req_*): one word per operation (func selects load
// predicate rules, load rule, register, deregister, set count or clear
// touched). Accepted when req_valid is high and req_stall is low.
// Response channel (rsp_*): exactly one word per request, carrying the edge
// and error flags plus the active, dropped and touched maps after the op.
//
// Flow: an accepted word is latched with its table reads; ST_EXEC carries
// out the op and ST_FINISH loads the response register. When a predicate
// appears or disappears, ST_EXEC starts the rule walker (ST_WALK), which
// steps through every rule slot, one rule counter read-modify-write per
// cycle; the walker's single 8-bit counter update paces the walk. One op
// is in flight at a time: req_stall is high from accept until the
// response is loaded, so no new word is taken before the last is through.
// The response sits in an output register; a new request is taken while
// it waits. If rsp_stall holds the previous word, the next result is held
// internally until the register frees up. Reset clears all counts, masks,
// rule settings and maps at once (valid bits per table entry), so the
// block is ready on the first cycle after.
module rule_activation_tracker
   import rat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_func,
   input  logic [PRED_W-1:0]     req_predicate_index,
   input  logic [RULE_W-1:0]     req_rule_index,
   input  logic [RULE_COUNT-1:0] req_rule_mask,
   input  logic [TOTAL_W-1:0]    req_rule_pred_total,
   input  logic                  req_rule_persistent,
   input  logic [COUNT_W-1:0]    req_tuple_count,
   input  logic                  req_is_new,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_edge_flag,
   output logic [RULE_COUNT-1:0] rsp_active_rules,
   output logic [RULE_COUNT-1:0] rsp_dropped_rules,
   output logic [PRED_COUNT-1:0] rsp_touched_predicates,
   output logic                  rsp_error
);

   // per-predicate tables
   logic [COUNT_W-1:0]    cnt_mem [PRED_COUNT];
   logic [RULE_COUNT-1:0] msk_mem [PRED_COUNT];

   state_type state_ff, state_in;

   logic [PRED_COUNT-1:0] cnt_vld_ff, cnt_vld_in;
   logic [PRED_COUNT-1:0] msk_vld_ff, msk_vld_in;
   logic [PRED_COUNT-1:0] touched_ff, touched_in;
   logic                  edge_ff, edge_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // latched request word
   func_type              func_ff;
   logic [PRED_W-1:0]     pidx_ff;
   logic [RULE_W-1:0]     ridx_ff;
   logic [RULE_COUNT-1:0] rmask_ff;
   logic [TOTAL_W-1:0]    rtotal_ff;
   logic                  rpers_ff;
   logic [COUNT_W-1:0]    amt_ff;
   logic                  new_ff;
   logic [COUNT_W-1:0]    cnt_rd_ff;
   logic [RULE_COUNT-1:0] msk_rd_ff;

   // response register
   logic                  rsp_edge_ff;
   logic [RULE_COUNT-1:0] rsp_active_ff;
   logic [RULE_COUNT-1:0] rsp_dropped_ff;
   logic [PRED_COUNT-1:0] rsp_touched_ff;
   logic                  rsp_err_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic [COUNT_W-1:0]    cnt_cur;
   logic                  cnt_zero;
   logic                  amt_zero;
   logic                  sub;
   logic [COUNT_W:0]      addend;
   logic [COUNT_W:0]      sum;
   logic                  cnt_we;
   logic [COUNT_W-1:0]    cnt_wdata;
   logic                  msk_we;
   logic [PRED_COUNT-1:0] p_bit;
   rule_wr_type           rule_wr;
   walk_cmd_type          walk_cmd;
   walk_sts_type          walk_sts;

   rat_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .rule_wr  (rule_wr),
      .walk_cmd (walk_cmd),
      .walk_sts (walk_sts)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // request latch and table reads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= func_type'(req_func);
         pidx_ff   <= req_predicate_index;
         ridx_ff   <= req_rule_index;
         rmask_ff  <= req_rule_mask;
         rtotal_ff <= req_rule_pred_total;
         rpers_ff  <= req_rule_persistent;
         amt_ff    <= req_tuple_count;
         new_ff    <= req_is_new;
         cnt_rd_ff <= cnt_mem[req_predicate_index];
         msk_rd_ff <= msk_mem[req_predicate_index];
      end
      if (cnt_we) begin
         cnt_mem[pidx_ff] <= cnt_wdata;
      end
      if (msk_we) begin
         msk_mem[pidx_ff] <= rmask_ff;
      end
   end

   // shared 33-bit add/subtract: carry out means overflow on register,
   // borrow (amount above count) on deregister
   always_comb begin
      cnt_cur  = cnt_vld_ff[pidx_ff] ? cnt_rd_ff : '0;
      cnt_zero = (cnt_cur == '0);
      amt_zero = (amt_ff == '0);
      sub      = (func_ff != FN_REGISTER);
      addend   = sub ? ~{1'b0, amt_ff} : {1'b0, amt_ff};
      sum      = {1'b0, cnt_cur} + addend + (COUNT_W + 1)'(sub);
      p_bit    = PRED_COUNT'(1) << pidx_ff;
   end

   always_comb begin
      state_in     = state_ff;
      edge_in      = edge_ff;
      err_in       = err_ff;
      touched_in   = touched_ff;
      cnt_we       = 1'b0;
      cnt_wdata    = sum[COUNT_W-1:0];
      msk_we       = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      rule_wr.we         = 1'b0;
      rule_wr.idx        = ridx_ff;
      rule_wr.total      = rtotal_ff;
      rule_wr.persistent = rpers_ff;

      walk_cmd.start = 1'b0;
      walk_cmd.up    = 1'b0;
      walk_cmd.mask  = msk_vld_ff[pidx_ff] ? msk_rd_ff : '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            edge_in  = 1'b0;
            err_in   = 1'b0;
            state_in = ST_FINISH;
            unique case (func_ff)
               FN_LOAD_PRED: begin
                  msk_we = 1'b1;
               end
               FN_LOAD_RULE: begin
                  rule_wr.we = 1'b1;
               end
               FN_REGISTER: begin
                  if (new_ff && cnt_zero) begin
                     edge_in        = 1'b1;
                     walk_cmd.start = 1'b1;
                     walk_cmd.up    = 1'b1;
                  end
                  err_in     = sum[COUNT_W];
                  cnt_we     = 1'b1;
                  cnt_wdata  = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                  touched_in = touched_ff | p_bit;
               end
               FN_DEREGISTER: begin
                  if (amt_zero || sum[COUNT_W]) begin
                     err_in = 1'b1;
                  end else begin
                     cnt_we = 1'b1;
                     if (sum[COUNT_W-1:0] == '0) begin
                        edge_in        = 1'b1;
                        walk_cmd.start = 1'b1;
                     end
                  end
               end
               FN_SET_COUNT: begin
                  cnt_we    = 1'b1;
                  cnt_wdata = amt_ff;
                  if (cnt_zero && !amt_zero) begin
                     edge_in        = 1'b1;
                     walk_cmd.start = 1'b1;
                     walk_cmd.up    = 1'b1;
                  end else if (!cnt_zero && amt_zero) begin
                     edge_in        = 1'b1;
                     walk_cmd.start = 1'b1;
                  end
               end
               FN_CLEAR_TOUCHED: begin
                  touched_in = '0;
               end
               default: ;   // unused codes: maps only
            endcase
            if (walk_cmd.start) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cnt_vld_in = cnt_vld_ff | (cnt_we ? p_bit : '0);
      msk_vld_in = msk_vld_ff | (msk_we ? p_bit : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_vld_ff   <= '0;
         msk_vld_ff   <= '0;
         touched_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_vld_ff   <= cnt_vld_in;
         msk_vld_ff   <= msk_vld_in;
         touched_ff   <= touched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      err_ff  <= err_in;
      if (rsp_load) begin
         rsp_edge_ff    <= edge_ff;
         rsp_err_ff     <= err_ff;
         rsp_active_ff  <= walk_sts.active;
         rsp_dropped_ff <= walk_sts.dropped;
         rsp_touched_ff <= touched_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_edge_flag          = rsp_edge_ff;
   assign rsp_error              = rsp_err_ff;
   assign rsp_active_rules       = rsp_active_ff;
   assign rsp_dropped_rules      = rsp_dropped_ff;
   assign rsp_touched_predicates = rsp_touched_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import rat_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // spare func codes: the block must treat them as no-ops
   localparam logic [2:0]         FN_SPARE_6     = 3'd6;
   localparam logic [2:0]         FN_SPARE_7     = 3'd7;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
   localparam int                 WATCHDOG_LIMIT = 4000;
   localparam int                 DRAIN_CYCLES   = RULE_COUNT + 16;
   localparam int                 OPS_PER_PHASE  = 230;

   // one request word
   typedef struct {
      logic [2:0]            func;
      logic [PRED_W-1:0]     pred;
      logic [RULE_W-1:0]     rule;
      logic [RULE_COUNT-1:0] mask;
      logic [TOTAL_W-1:0]    total;
      logic                  persistent;
      logic [COUNT_W-1:0]    amount;
      logic                  is_new;
   } op_word_type;

   // one response word
   typedef struct {
      logic                  edge_flag;
      logic [RULE_COUNT-1:0] active;
      logic [RULE_COUNT-1:0] dropped;
      logic [PRED_COUNT-1:0] touched;
      logic                  error;
   } tracker_rsp_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_func = '0;
   logic [PRED_W-1:0]     req_predicate_index = '0;
   logic [RULE_W-1:0]     req_rule_index = '0;
   logic [RULE_COUNT-1:0] req_rule_mask = '0;
   logic [TOTAL_W-1:0]    req_rule_pred_total = '0;
   logic                  req_rule_persistent = 1'b0;
   logic [COUNT_W-1:0]    req_tuple_count = '0;
   logic                  req_is_new = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_edge_flag;
   logic [RULE_COUNT-1:0] rsp_active_rules;
   logic [RULE_COUNT-1:0] rsp_dropped_rules;
   logic [PRED_COUNT-1:0] rsp_touched_predicates;
   logic                  rsp_error;

   rule_activation_tracker u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_predicate_index    (req_predicate_index),
      .req_rule_index         (req_rule_index),
      .req_rule_mask          (req_rule_mask),
      .req_rule_pred_total    (req_rule_pred_total),
      .req_rule_persistent    (req_rule_persistent),
      .req_tuple_count        (req_tuple_count),
      .req_is_new             (req_is_new),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_edge_flag          (rsp_edge_flag),
      .rsp_active_rules       (rsp_active_rules),
      .rsp_dropped_rules      (rsp_dropped_rules),
      .rsp_touched_predicates (rsp_touched_predicates),
      .rsp_error              (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Tracker model: a private copy of every table and map in the block.
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0]    mdl_count [PRED_COUNT];
   logic [AVAIL_W-1:0]    mdl_avail [RULE_COUNT];
   logic [RULE_COUNT-1:0] mdl_mask  [PRED_COUNT];
   logic [TOTAL_W-1:0]    mdl_need  [RULE_COUNT];
   logic                  mdl_pers  [RULE_COUNT];
   logic [RULE_COUNT-1:0] mdl_active;
   logic [RULE_COUNT-1:0] mdl_dropped;
   logic [PRED_COUNT-1:0] mdl_touched;

   tracker_rsp_type expected_rsp_q[$];
   op_word_type     pending_ops[$];
   op_word_type     bus_op;
   tracker_rsp_type got_rsp;
   tracker_rsp_type want_rsp;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int idle_cycles    = 0;

   // Predicate appeared (up) or vanished: step every non-persistent rule
   // it feeds. Counters are 8 bits and wrap; a rule turns active when its
   // counter steps up onto its total, dropped when it steps down off it.
   function automatic void walk_rules(int p, bit up);
      for (int r = 0; r < RULE_COUNT; r++) begin
         if (mdl_mask[p][r] && !mdl_pers[r]) begin
            if (up) begin
               mdl_avail[r] = mdl_avail[r] + 1'b1;
               if (mdl_avail[r] == mdl_need[r]) begin
                  mdl_active[r]  = 1'b1;
                  mdl_dropped[r] = 1'b0;
               end
            end else begin
               if (mdl_avail[r] == mdl_need[r]) begin
                  mdl_active[r]  = 1'b0;
                  mdl_dropped[r] = 1'b1;
               end
               mdl_avail[r] = mdl_avail[r] - 1'b1;
            end
         end
      end
   endfunction

   // Apply one accepted word to the model, return the response it owes.
   function automatic tracker_rsp_type apply_op(op_word_type op);
      tracker_rsp_type    o;
      logic [COUNT_W-1:0] c;
      o.edge_flag = 1'b0;
      o.error     = 1'b0;
      c = mdl_count[op.pred];
      case (op.func)
         FN_LOAD_PRED: mdl_mask[op.pred] = op.mask;
         FN_LOAD_RULE: begin
            mdl_need[op.rule] = op.total;
            mdl_pers[op.rule] = op.persistent;
         end
         FN_REGISTER: begin
            // without is_new availability never moves, even from zero
            if (op.is_new && c == '0) begin
               o.edge_flag = 1'b1;
               walk_rules(int'(op.pred), 1'b1);
            end
            if (op.amount > COUNT_MAX - c) begin
               mdl_count[op.pred] = COUNT_MAX;
               o.error = 1'b1;
            end else begin
               mdl_count[op.pred] = c + op.amount;
            end
            mdl_touched[op.pred] = 1'b1;
         end
         FN_DEREGISTER: begin
            // zero amount or underflow: flagged, nothing changes
            if (op.amount == '0 || op.amount > c) begin
               o.error = 1'b1;
            end else begin
               if (op.amount == c) begin
                  o.edge_flag = 1'b1;
                  walk_rules(int'(op.pred), 1'b0);
               end
               mdl_count[op.pred] = c - op.amount;
            end
         end
         FN_SET_COUNT: begin
            if (c == '0 && op.amount != '0) begin
               o.edge_flag = 1'b1;
               walk_rules(int'(op.pred), 1'b1);
            end else if (c != '0 && op.amount == '0) begin
               o.edge_flag = 1'b1;
               walk_rules(int'(op.pred), 1'b0);
            end
            mdl_count[op.pred] = op.amount;
         end
         FN_CLEAR_TOUCHED: mdl_touched = '0;
         default: ;
      endcase
      o.active  = mdl_active;
      o.dropped = mdl_dropped;
      o.touched = mdl_touched;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation. Counts and masks are shadowed at queue time so
   // deregisters can be aimed at the exact count (the edge) or past it.
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0]    gen_count [PRED_COUNT];
   logic [RULE_COUNT-1:0] gen_mask  [PRED_COUNT];

   function automatic op_word_type make_op(logic [2:0] func, int p, int r,
                                           logic [RULE_COUNT-1:0] mask, int total,
                                           int pers, logic [COUNT_W-1:0] amount,
                                           int is_new);
      op_word_type op;
      op.func       = func;
      op.pred       = PRED_W'(p);
      op.rule       = RULE_W'(r);
      op.mask       = mask;
      op.total      = TOTAL_W'(total);
      op.persistent = pers[0];
      op.amount     = amount;
      op.is_new     = is_new[0];
      return op;
   endfunction

   function automatic op_word_type rand_op();
      return make_op(3'($urandom_range(7)), $urandom_range(31), $urandom_range(63),
                     {$urandom, $urandom}, $urandom_range(255), $urandom_range(1),
                     $urandom, $urandom_range(1));
   endfunction

   // mostly sparse masks so rules need only a handful of predicates
   function automatic logic [RULE_COUNT-1:0] pick_mask();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50)      return {$urandom & $urandom & $urandom,
                                 $urandom & $urandom & $urandom};
      else if (sel < 70) return {$urandom & $urandom & $urandom & $urandom,
                                 $urandom & $urandom & $urandom & $urandom};
      else if (sel < 85) return {$urandom, $urandom};
      else if (sel < 90) return '0;
      else if (sel < 95) return '1;
      else               return 64'd1 << $urandom_range(63);
   endfunction

   // rule total: usually the number of predicates feeding it, so it can fire
   function automatic logic [TOTAL_W-1:0] pick_total(int r);
      int col;
      int sel;
      col = 0;
      for (int p = 0; p < PRED_COUNT; p++) col += int'(gen_mask[p][r]);
      sel = $urandom_range(99);
      if (sel < 70)      return TOTAL_W'(col);
      else if (sel < 80) return TOTAL_W'($urandom_range(1) ? col + 1 : col - 1);
      else if (sel < 90) return TOTAL_W'($urandom_range(3));
      else               return TOTAL_W'($urandom_range(255));
   endfunction

   task automatic queue_op(op_word_type op);
      logic [COUNT_W-1:0] c;
      c = gen_count[op.pred];
      case (op.func)
         FN_LOAD_PRED: gen_mask[op.pred] = op.mask;
         FN_REGISTER:
            gen_count[op.pred] = (op.amount > COUNT_MAX - c) ? COUNT_MAX : c + op.amount;
         FN_DEREGISTER:
            if (op.amount != '0 && op.amount <= c) gen_count[op.pred] = c - op.amount;
         FN_SET_COUNT: gen_count[op.pred] = op.amount;
         default: ;
      endcase
      pending_ops.push_back(op);
   endtask

   task automatic queue_setup(int n_preds, int n_rules);
      op_word_type op;
      for (int i = 0; i < n_preds; i++) begin
         op = rand_op();
         op.func = FN_LOAD_PRED;
         if (n_preds == PRED_COUNT) op.pred = PRED_W'(i);
         op.mask = pick_mask();
         queue_op(op);
      end
      for (int i = 0; i < n_rules; i++) begin
         op = rand_op();
         op.func = FN_LOAD_RULE;
         if (n_rules == RULE_COUNT) op.rule = RULE_W'(i);
         op.total = pick_total(int'(op.rule));
         op.persistent = ($urandom_range(9) == 0);
         queue_op(op);
      end
   endtask

   task automatic queue_random_op();
      op_word_type        op;
      int                 sel;
      int                 sub;
      logic [COUNT_W-1:0] c;
      op  = rand_op();
      sel = $urandom_range(99);
      sub = $urandom_range(99);
      c   = gen_count[op.pred];
      if (sel < 30) begin
         op.func   = FN_REGISTER;
         op.is_new = ($urandom_range(9) < 8);
         if (sub < 5)       op.amount = '0;
         else if (sub < 80) op.amount = $urandom_range(1, 3);
         else if (sub < 92) op.amount = $urandom;
         else               op.amount = COUNT_MAX - $urandom_range(2);
      end else if (sel < 55) begin
         op.func = FN_DEREGISTER;
         if (sub < 55)                op.amount = c;
         else if (sub < 75 && c > 1)  op.amount = $urandom_range(1, c - 1);
         else if (sub < 85)           op.amount = c + 1'b1;
         else if (sub < 92)           op.amount = '0;
      end else if (sel < 70) begin
         op.func = FN_SET_COUNT;
         if (sub < 40)      op.amount = '0;
         else if (sub < 85) op.amount = $urandom_range(1, 4);
      end else if (sel < 76) begin
         op.func = FN_LOAD_PRED;
         op.mask = pick_mask();
      end else if (sel < 84) begin
         op.func       = FN_LOAD_RULE;
         op.total      = pick_total(int'(op.rule));
         op.persistent = ($urandom_range(9) == 0);
      end else if (sel < 88) begin
         op.func = FN_CLEAR_TOUCHED;
      end else if (sel < 90) begin
         op.func = $urandom_range(1) ? FN_SPARE_6 : FN_SPARE_7;
      end
      // remaining 10%: fully random word as noise
      queue_op(op);
   endtask

   // hold off new words until every response is back, then let the
   // walker settle
   task automatic drain();
      while (pending_ops.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: present the next pending word once the slot frees up; a
   // presented word holds until accepted.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_rsp_q.push_back(apply_op(bus_op));
         if (!req_valid || !req_stall) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_op = pending_ops.pop_front();
               req_func            <= bus_op.func;
               req_predicate_index <= bus_op.pred;
               req_rule_index      <= bus_op.rule;
               req_rule_mask       <= bus_op.mask;
               req_rule_pred_total <= bus_op.total;
               req_rule_persistent <= bus_op.persistent;
               req_tuple_count     <= bus_op.amount;
               req_is_new          <= bus_op.is_new;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: each response word against the oldest expectation.
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_rsp.edge_flag = rsp_edge_flag;
            got_rsp.active    = rsp_active_rules;
            got_rsp.dropped   = rsp_dropped_rules;
            got_rsp.touched   = rsp_touched_predicates;
            got_rsp.error     = rsp_error;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none expected: expected nothing, actual %h %h",
                        $time, got_rsp.active, got_rsp.dropped);
               fail_count++;
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               check_field("edge_flag", 64'(want_rsp.edge_flag), 64'(got_rsp.edge_flag));
               check_field("active_rules", want_rsp.active, got_rsp.active);
               check_field("dropped_rules", want_rsp.dropped, got_rsp.dropped);
               check_field("touched_predicates", 64'(want_rsp.touched),
                           64'(got_rsp.touched));
               check_field("error", 64'(want_rsp.error), 64'(got_rsp.error));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int p = 0; p < PRED_COUNT; p++) begin
         mdl_count[p] = '0;
         mdl_mask[p]  = '0;
         gen_count[p] = '0;
         gen_mask[p]  = '0;
      end
      for (int r = 0; r < RULE_COUNT; r++) begin
         mdl_avail[r] = '0;
         mdl_need[r]  = '0;
         mdl_pers[r]  = 1'b0;
      end
      mdl_active  = '0;
      mdl_dropped = '0;
      mdl_touched = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: no idling on either side
      queue_op(make_op(FN_LOAD_PRED, 0, 0, '1, 0, 0, 0, 0));
      queue_op(make_op(FN_LOAD_PRED, 1, 0, 64'd1, 0, 0, 0, 0));
      queue_op(make_op(FN_LOAD_PRED, 31, 0, 64'h8000_0000_0000_0001, 0, 0, 0, 0));
      queue_op(make_op(FN_LOAD_RULE, 0, 0, '0, 2, 0, 0, 0));
      queue_op(make_op(FN_LOAD_RULE, 0, 63, '0, 1, 0, 0, 0));
      queue_op(make_op(FN_LOAD_RULE, 0, 1, '0, 1, 1, 0, 0));      // persistent rule
      queue_op(make_op(FN_REGISTER, 0, 0, '0, 0, 0, 1, 1));       // p0 appears
      queue_op(make_op(FN_REGISTER, 1, 0, '0, 0, 0, 5, 0));       // no is_new from zero
      queue_op(make_op(FN_REGISTER, 31, 0, '0, 0, 0, 1, 1));      // rule 0 fires, 63 stays active
      queue_op(make_op(FN_REGISTER, 0, 0, '0, 0, 0, COUNT_MAX, 1)); // saturate
      queue_op(make_op(FN_DEREGISTER, 31, 0, '0, 0, 0, 0, 0));    // zero amount
      queue_op(make_op(FN_DEREGISTER, 31, 0, '0, 0, 0, 2, 0));    // underflow
      queue_op(make_op(FN_DEREGISTER, 31, 0, '0, 0, 0, 1, 0));    // goes to none
      queue_op(make_op(FN_SET_COUNT, 2, 0, '0, 0, 0, 7, 0));
      queue_op(make_op(FN_SET_COUNT, 2, 0, '0, 0, 0, 0, 0));
      queue_op(make_op(FN_SET_COUNT, 2, 0, '0, 0, 0, 0, 0));      // already none
      queue_op(make_op(FN_CLEAR_TOUCHED, 0, 0, '0, 0, 0, 0, 0));
      queue_op(make_op(FN_SPARE_6, 31, 63, '1, 255, 1, COUNT_MAX, 1));
      queue_op(make_op(FN_SPARE_7, 0, 0, '0, 0, 0, 0, 0));
      queue_op(make_op(FN_LOAD_RULE, 0, 63, '0, 255, 1, 0, 0));
      queue_op(make_op(FN_REGISTER, 5, 0, '0, 0, 0, 0, 1));       // edge with zero amount
      queue_op(make_op(FN_DEREGISTER, 0, 0, '0, 0, 0, COUNT_MAX, 0));
      drain();

      // random phases, cycling through the idle/stall mixes; each drain is
      // a full pause of the sender until all responses are back
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         if (ph == 0) queue_setup(PRED_COUNT, RULE_COUNT);
         else queue_setup(8, 16);
         for (int i = 0; i < OPS_PER_PHASE; i++) queue_random_op();
         drain();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
